// ----- hdl/ledbb_pkg.sv -----
// Package for the LED blink and breathing controller.
// Holds the field widths, command codes, counter limits and the controller state type.
// Has no dependencies; ledbb_next, the top level and the testbench import it.
`default_nettype none

package ledbb_pkg;

  localparam int KIND_W      = 2;
  localparam int SEL_W       = 2;
  localparam int MODE_W      = 3;
  localparam int DIV_W       = 2;
  localparam int TCNT_W      = 3;
  localparam int PHASE_W     = 7;
  localparam int HOLD_W      = 6;
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 3;

  localparam logic [PHASE_W-1:0] PWM_PHASE_MAX     = 7'd100;
  localparam logic [PHASE_W-1:0] BREATH_PHASE_INIT = 7'd99;
  localparam logic [PHASE_W-1:0] BREATH_WIDTH_INIT = 7'd100;
  localparam logic [PHASE_W-1:0] RAMP_LOW          = 7'd2;
  localparam logic [HOLD_W-1:0]  HOLD_MAX          = 6'd50;
  localparam logic [DIV_W-1:0]   BLINK_DIV_MAX     = 2'd2;
  localparam logic [TCNT_W-1:0]  TEMP_TOGGLE_MAX   = 3'd6;

  typedef enum logic [KIND_W-1:0] {
    KIND_CMD  = 2'd0,
    KIND_SLOW = 2'd1,
    KIND_FAST = 2'd2
  } kind_t;

  typedef enum logic [SEL_W-1:0] {
    SEL_GREEN = 2'd0,
    SEL_RED   = 2'd1,
    SEL_BOTH  = 2'd2
  } sel_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF    = 3'd0,
    MODE_ON     = 3'd1,
    MODE_BLINK  = 3'd2,
    MODE_TEMP   = 3'd3,
    MODE_BREATH = 3'd4
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEL_W-1:0]  led_select;
    logic [MODE_W-1:0] mode;
  } ledbb_item_t;

  typedef struct packed {
    mode_t              green_state;
    mode_t              red_state;
    mode_t              saved_state;
    logic [DIV_W-1:0]   blink_div;
    logic [TCNT_W-1:0]  temp_cnt;
    logic               green_pin;
    logic               red_pin;
    logic               breath_en;
    logic [PHASE_W-1:0] pwm_phase;
    logic [HOLD_W-1:0]  hold_cnt;
    logic [PHASE_W-1:0] pulse_width;
    logic               ramp_up;
  } ledbb_state_t;

endpackage

`default_nettype wire

// ----- hdl/ledbb_next.sv -----
// Next-state logic of the LED controller: mode commands, blink divider and breathing PWM.
// Purely combinational; depends on ledbb_pkg.
`default_nettype none

module ledbb_next (
  input  ledbb_pkg::ledbb_state_t state,
  input  ledbb_pkg::ledbb_item_t  item,
  output ledbb_pkg::ledbb_state_t state_nxt
);
  import ledbb_pkg::*;

  function automatic ledbb_state_t apply_mode(ledbb_state_t s, logic [SEL_W-1:0] sel,
                                              logic [MODE_W-1:0] m);
    ledbb_state_t r;
    mode_t        st;
    logic         pin;
    logic         is_green;
    logic         level;
    r        = s;
    is_green = (sel == SEL_GREEN);
    st       = is_green ? s.green_state : s.red_state;
    pin      = is_green ? s.green_pin : s.red_pin;
    level    = (m == MODE_ON);
    if (sel == SEL_GREEN || sel == SEL_RED) begin
      case (m)
        MODE_TEMP: begin
          if (st != MODE_TEMP) begin
            r.saved_state = st;
            st            = MODE_TEMP;
            r.breath_en   = 1'b0;
          end
        end
        MODE_BLINK: begin
          st          = MODE_BLINK;
          r.breath_en = 1'b0;
        end
        MODE_ON: begin
          st          = MODE_ON;
          pin         = 1'b1;
          r.breath_en = 1'b0;
        end
        MODE_OFF: begin
          st          = MODE_OFF;
          pin         = 1'b0;
          r.breath_en = 1'b0;
        end
        MODE_BREATH: begin
          if (is_green) begin
            st            = MODE_BREATH;
            r.pwm_phase   = BREATH_PHASE_INIT;
            r.hold_cnt    = '0;
            r.pulse_width = BREATH_WIDTH_INIT;
            r.ramp_up     = 1'b0;
            r.breath_en   = 1'b1;
          end
        end
        default: begin
          st = MODE_OFF;
          if (!is_green) begin
            pin = 1'b0;
          end
          r.breath_en = 1'b0;
        end
      endcase
      if (is_green) begin
        r.green_state = st;
        r.green_pin   = pin;
      end else begin
        r.red_state = st;
        r.red_pin   = pin;
      end
    end else begin
      r.green_pin = level;
      r.red_pin   = level;
    end
    return r;
  endfunction

  function automatic ledbb_state_t blink_step(ledbb_state_t s, logic [SEL_W-1:0] sel,
                                              mode_t st);
    ledbb_state_t      r;
    logic [DIV_W-1:0]  div;
    logic [TCNT_W-1:0] cnt;
    r   = s;
    div = s.blink_div + 1'b1;
    cnt = s.temp_cnt + 1'b1;
    if (div > BLINK_DIV_MAX) begin
      r.blink_div = '0;
      if (sel == SEL_GREEN) begin
        r.green_pin = ~s.green_pin;
      end else begin
        r.red_pin = ~s.red_pin;
      end
      if (st == MODE_TEMP) begin
        r.temp_cnt = cnt;
        if (cnt > TEMP_TOGGLE_MAX) begin
          r          = apply_mode(r, sel, r.saved_state);
          r.temp_cnt = '0;
        end
      end
    end else begin
      r.blink_div = div;
    end
    return r;
  endfunction

  function automatic ledbb_state_t pwm_step(ledbb_state_t s);
    ledbb_state_t       r;
    logic [PHASE_W-1:0] phase;
    logic [HOLD_W-1:0]  hold;
    logic [PHASE_W-1:0] width;
    logic               ramp;
    r     = s;
    phase = s.pwm_phase + 1'b1;
    hold  = s.hold_cnt;
    width = s.pulse_width;
    ramp  = s.ramp_up;
    if (phase > PWM_PHASE_MAX) begin
      phase = '0;
      hold  = hold + 1'b1;
      if (hold > HOLD_MAX) begin
        hold = '0;
        if (ramp) begin
          width = width + 1'b1;
          if (width > PWM_PHASE_MAX) begin
            ramp = 1'b0;
          end
        end else begin
          width = width - 1'b1;
          if (width < RAMP_LOW) begin
            ramp = 1'b1;
          end
        end
      end
    end
    if (phase == '0) begin
      r.green_pin = 1'b0;
    end else if (phase == width) begin
      r.green_pin = 1'b1;
    end
    r.pwm_phase   = phase;
    r.hold_cnt    = hold;
    r.pulse_width = width;
    r.ramp_up     = ramp;
    return r;
  endfunction

  always_comb begin
    state_nxt = state;
    case (item.kind)
      KIND_CMD: begin
        state_nxt = apply_mode(state, item.led_select, item.mode);
      end
      KIND_SLOW: begin
        if (state.green_state == MODE_BLINK || state.green_state == MODE_TEMP) begin
          state_nxt = blink_step(state, SEL_GREEN, state.green_state);
        end else if (state.red_state == MODE_BLINK || state.red_state == MODE_TEMP) begin
          state_nxt = blink_step(state, SEL_RED, state.red_state);
        end
      end
      KIND_FAST: begin
        if (state.breath_en) begin
          state_nxt = pwm_step(state);
        end
      end
      default: begin
        state_nxt = state;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/led_blink_breath_controller_core.sv -----
// Top level of the LED blink and breathing controller: input register, state register,
// output register and stream handshakes. Depends on ledbb_pkg and ledbb_next.
// Path: an accepted item is held in the input register, and its result is then
// registered in the output register.
// Throughput: one item per cycle unless the output stalls; the state register
// updates in the same cycle an item moves from the input to the output register.
// Reset: synchronous, active low; both channel stages empty and all LED state cleared.
`default_nettype none

module led_blink_breath_controller_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata: led_select[1:0], mode[4:2], zero [7:5]
  input  logic [ledbb_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: kind[1:0]
  input  logic [ledbb_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata: green_out[0], red_out[1], breathing_active[2], zero [7:3]
  output logic [ledbb_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import ledbb_pkg::*;

  logic                   in_vld_r;
  ledbb_item_t            item_r;
  ledbb_item_t            item_in;
  ledbb_state_t           state_r;
  ledbb_state_t           state_nxt;
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   advance;

  assign item_in.kind       = in_tuser[KIND_W-1:0];
  assign item_in.led_select = in_tdata[SEL_W-1:0];
  assign item_in.mode       = in_tdata[SEL_W +: MODE_W];

  assign advance    = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready  = !in_vld_r || advance;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  ledbb_next u_next (
    .state     (state_r),
    .item      (item_r),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        state_r   <= state_nxt;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_in;
    end
    if (advance) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, state_nxt.breath_en, state_nxt.red_pin,
                     state_nxt.green_pin};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ledbb_checker.sv -----
// Port-level checker for the LED controller, bound to the top level below.
// Watches only the stream ports; no package dependency.
`default_nettype none

module ledbb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // A stalled result must hold its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or vanished.");

  // Reset empties the result stage.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result valid after reset.");

  // With the result stage empty, the input side can always take a transfer.
  assert property (@(posedge clk) disable iff (!rst_n) !out_tvalid |-> in_tready)
    else $error("Input stalled while result stage is empty.");

  // Padding bits of a result are zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:3] == 5'b0)
    else $error("Nonzero padding in result.");

endmodule

bind led_blink_breath_controller_core ledbb_checker u_ledbb_checker (.*);

`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for led_blink_breath_controller_core: a table of directed items, then random
// command, tick and breathing sequences, checked against a predictor of the LED state or
// against levels given in the table; depends on ledbb_pkg and the RTL of the block.
`default_nettype none

module testbench;
  import ledbb_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int DIRECTED_ROWS = 27;

  localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
  localparam logic [SEL_W-1:0]  SEL_BOTH_ALT = 2'd3;
  localparam logic [MODE_W-1:0] MODE_BAD_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_BAD_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_BAD_HI  = 3'd7;

  typedef struct packed {
    logic green;
    logic red;
    logic breath;
  } lamp_levels_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEL_W-1:0]  sel;
    logic [MODE_W-1:0] mode;
    logic              typed;
    lamp_levels_t      levels;
  } stim_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int errors         = 0;
  int quiet_cycles   = 0;

  lamp_levels_t expected_levels[$];

  mode_t              green_mode   = MODE_OFF;
  mode_t              red_mode     = MODE_OFF;
  mode_t              held_mode    = MODE_OFF;
  logic [DIV_W-1:0]   tick_div     = '0;
  logic [TCNT_W-1:0]  temp_toggles = '0;
  logic               green_lvl    = 1'b0;
  logic               red_lvl      = 1'b0;
  logic               breathing    = 1'b0;
  logic [PHASE_W-1:0] phase        = '0;
  logic [HOLD_W-1:0]  hold_periods = '0;
  logic [PHASE_W-1:0] duty         = '0;
  logic               duty_rising  = 1'b0;

  stim_row_t plan [DIRECTED_ROWS] = '{
    '{KIND_SLOW,   SEL_GREEN,    MODE_OFF,     1'b1, '{1'b0, 1'b0, 1'b0}},
    '{KIND_FAST,   SEL_GREEN,    MODE_OFF,     1'b1, '{1'b0, 1'b0, 1'b0}},
    '{KIND_UNUSED, SEL_BOTH_ALT, MODE_BAD_HI,  1'b1, '{1'b0, 1'b0, 1'b0}},
    '{KIND_CMD,    SEL_BOTH,     MODE_ON,      1'b1, '{1'b1, 1'b1, 1'b0}},
    '{KIND_CMD,    SEL_BOTH_ALT, MODE_BAD_HI,  1'b1, '{1'b0, 1'b0, 1'b0}},
    '{KIND_CMD,    SEL_GREEN,    MODE_ON,      1'b1, '{1'b1, 1'b0, 1'b0}},
    '{KIND_CMD,    SEL_RED,      MODE_ON,      1'b1, '{1'b1, 1'b1, 1'b0}},
    '{KIND_CMD,    SEL_GREEN,    MODE_BAD_HI,  1'b1, '{1'b1, 1'b1, 1'b0}},
    '{KIND_CMD,    SEL_RED,      MODE_BAD_LO,  1'b1, '{1'b1, 1'b0, 1'b0}},
    '{KIND_CMD,    SEL_RED,      MODE_BREATH,  1'b1, '{1'b1, 1'b0, 1'b0}},
    '{KIND_CMD,    SEL_GREEN,    MODE_BREATH,  1'b1, '{1'b1, 1'b0, 1'b1}},
    '{KIND_FAST,   SEL_GREEN,    MODE_OFF,     1'b0, '0},
    '{KIND_FAST,   SEL_BOTH_ALT, MODE_BAD_HI,  1'b0, '0},
    '{KIND_FAST,   SEL_RED,      MODE_ON,      1'b0, '0},
    '{KIND_CMD,    SEL_GREEN,    MODE_OFF,     1'b1, '{1'b0, 1'b0, 1'b0}},
    '{KIND_CMD,    SEL_RED,      MODE_BLINK,   1'b0, '0},
    '{KIND_SLOW,   SEL_GREEN,    MODE_OFF,     1'b0, '0},
    '{KIND_SLOW,   SEL_BOTH_ALT, MODE_BAD_HI,  1'b0, '0},
    '{KIND_SLOW,   SEL_RED,      MODE_TEMP,    1'b0, '0},
    '{KIND_CMD,    SEL_GREEN,    MODE_TEMP,    1'b0, '0},
    '{KIND_CMD,    SEL_GREEN,    MODE_TEMP,    1'b0, '0},
    '{KIND_SLOW,   SEL_GREEN,    MODE_OFF,     1'b0, '0},
    '{KIND_CMD,    SEL_BOTH,     MODE_BREATH,  1'b0, '0},
    '{KIND_CMD,    SEL_RED,      MODE_BAD_MID, 1'b0, '0},
    '{KIND_CMD,    SEL_GREEN,    MODE_BAD_LO,  1'b0, '0},
    '{KIND_FAST,   SEL_GREEN,    MODE_BREATH,  1'b0, '0},
    '{KIND_UNUSED, SEL_GREEN,    MODE_OFF,     1'b0, '0}
  };

  led_blink_breath_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void set_led_mode(input logic [SEL_W-1:0] s, input logic [MODE_W-1:0] m);
    mode_t cur;
    logic  lvl;
    if (s == SEL_GREEN || s == SEL_RED) begin
      cur = (s == SEL_GREEN) ? green_mode : red_mode;
      lvl = (s == SEL_GREEN) ? green_lvl : red_lvl;
      case (m)
        MODE_TEMP: begin
          if (cur != MODE_TEMP) begin
            held_mode = cur;
            cur = MODE_TEMP;
            breathing = 1'b0;
          end
        end
        MODE_BLINK: begin
          cur = MODE_BLINK;
          breathing = 1'b0;
        end
        MODE_ON: begin
          cur = MODE_ON;
          lvl = 1'b1;
          breathing = 1'b0;
        end
        MODE_OFF: begin
          cur = MODE_OFF;
          lvl = 1'b0;
          breathing = 1'b0;
        end
        MODE_BREATH: begin
          if (s == SEL_GREEN) begin
            cur = MODE_BREATH;
            phase = BREATH_PHASE_INIT;
            hold_periods = '0;
            duty = BREATH_WIDTH_INIT;
            duty_rising = 1'b0;
            breathing = 1'b1;
          end
        end
        default: begin
          cur = MODE_OFF;
          if (s == SEL_RED) lvl = 1'b0;
          breathing = 1'b0;
        end
      endcase
      if (s == SEL_GREEN) begin
        green_mode = cur;
        green_lvl = lvl;
      end else begin
        red_mode = cur;
        red_lvl = lvl;
      end
    end else begin
      green_lvl = (m == MODE_ON);
      red_lvl = (m == MODE_ON);
    end
  endfunction

  function automatic void blink_toggle(input logic [SEL_W-1:0] s, input mode_t st);
    tick_div = tick_div + 1'b1;
    if (tick_div > BLINK_DIV_MAX) begin
      tick_div = '0;
      if (s == SEL_GREEN) green_lvl = ~green_lvl;
      else red_lvl = ~red_lvl;
      if (st == MODE_TEMP) begin
        temp_toggles = temp_toggles + 1'b1;
        if (temp_toggles > TEMP_TOGGLE_MAX) begin
          set_led_mode(s, held_mode);
          temp_toggles = '0;
        end
      end
    end
  endfunction

  function automatic void pwm_advance();
    phase = phase + 1'b1;
    if (phase > PWM_PHASE_MAX) begin
      phase = '0;
      hold_periods = hold_periods + 1'b1;
      if (hold_periods > HOLD_MAX) begin
        hold_periods = '0;
        if (duty_rising) begin
          duty = duty + 1'b1;
          if (duty > PWM_PHASE_MAX) duty_rising = 1'b0;
        end else begin
          duty = duty - 1'b1;
          if (duty < RAMP_LOW) duty_rising = 1'b1;
        end
      end
    end
    if (phase == '0) green_lvl = 1'b0;
    else if (phase == duty) green_lvl = 1'b1;
  endfunction

  function automatic lamp_levels_t advance_lamps(input logic [KIND_W-1:0] k,
                                                 input logic [SEL_W-1:0] s,
                                                 input logic [MODE_W-1:0] m);
    lamp_levels_t now;
    case (k)
      KIND_CMD: set_led_mode(s, m);
      KIND_SLOW: begin
        if (green_mode == MODE_BLINK || green_mode == MODE_TEMP) begin
          blink_toggle(SEL_GREEN, green_mode);
        end else if (red_mode == MODE_BLINK || red_mode == MODE_TEMP) begin
          blink_toggle(SEL_RED, red_mode);
        end
      end
      KIND_FAST: begin
        if (breathing) pwm_advance();
      end
      default: ;
    endcase
    now.green = green_lvl;
    now.red = red_lvl;
    now.breath = breathing;
    return now;
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] k, input logic [SEL_W-1:0] s,
                           input logic [MODE_W-1:0] m, input logic typed,
                           input lamp_levels_t given);
    lamp_levels_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= {{(IN_TDATA_W - SEL_W - MODE_W){1'b0}}, m, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = advance_lamps(k, s, m);
    expected_levels.push_back(typed ? given : predicted);
    items_sent++;
  endtask

  task automatic send_noise_item();
    send_item(KIND_W'($urandom_range(3)), SEL_W'($urandom_range(3)),
              MODE_W'($urandom_range(7)), 1'b0, '0);
  endtask

  task automatic send_mostly(input logic [KIND_W-1:0] k);
    if ($urandom_range(9) != 0) begin
      send_item(k, SEL_W'($urandom_range(3)), MODE_W'($urandom_range(7)), 1'b0, '0);
    end else begin
      send_noise_item();
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int               stop_at;
    int               seg;
    int               len;
    logic [SEL_W-1:0] led;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(19) == 0) drain_results();
      seg = $urandom_range(99);
      len = 0;
      if (seg < 30) begin
        led = SEL_W'($urandom_range(1));
        if (led == SEL_RED) send_item(KIND_CMD, SEL_GREEN, MODE_W'($urandom_range(1)), 1'b0, '0);
        if ($urandom_range(1) == 1) send_item(KIND_CMD, led, MODE_W'($urandom_range(4)), 1'b0, '0);
        send_item(KIND_CMD, led, MODE_TEMP, 1'b0, '0);
        len = $urandom_range(30, 18);
        repeat (len) send_mostly(KIND_SLOW);
      end else if (seg < 55) begin
        send_item(KIND_CMD, SEL_GREEN, MODE_BREATH, 1'b0, '0);
        len = $urandom_range(200, 60);
        repeat (len) send_mostly(KIND_FAST);
      end else if (seg < 75) begin
        send_item(KIND_CMD, SEL_W'($urandom_range(1)), MODE_BLINK, 1'b0, '0);
        len = $urandom_range(15, 5);
        repeat (len) send_mostly(KIND_SLOW);
      end else begin
        len = $urandom_range(15, 4);
        repeat (len) send_noise_item();
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    lamp_levels_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_levels.size() == 0) begin
        $error("unexpected result transfer: out_tdata %0h", out_tdata);
        errors++;
      end else begin
        want = expected_levels.pop_front();
        if (out_tdata[0] !== want.green) begin
          $error("green_out: expected %0b, got %0b", want.green, out_tdata[0]);
          errors++;
        end
        if (out_tdata[1] !== want.red) begin
          $error("red_out: expected %0b, got %0b", want.red, out_tdata[1]);
          errors++;
        end
        if (out_tdata[2] !== want.breath) begin
          $error("breathing_active: expected %0b, got %0b", want.breath, out_tdata[2]);
          errors++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 38;
    recv_stall_pct = 86;
    for (int idx = 0; idx < DIRECTED_ROWS; idx++) begin
      send_item(plan[idx].kind, plan[idx].sel, plan[idx].mode, plan[idx].typed,
                plan[idx].levels);
    end
    run_random(330);
    drain_results();
    send_idle_pct = 86;
    recv_stall_pct = 38;
    run_random(350);
    drain_results();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(330);
    drain_results();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/ledbb_pkg.sv
hdl/ledbb_next.sv
hdl/led_blink_breath_controller_core.sv
hdl/ledbb_checker.sv
sim/testbench.sv
